// File: hw/rtl/sh24_pkg.sv
`timescale 1ns / 1ps

package sh24_pkg;

	localparam int unsigned WordW      = 64;
	localparam int unsigned CountW     = 4;
	localparam int unsigned LenW       = 8;
	localparam int unsigned CfgIdxW    = 2;
	localparam int unsigned BytesPerW  = WordW / 8;
	localparam int unsigned DrainRounds = 4;
	localparam int unsigned DrainCntW  = $clog2(DrainRounds);

	localparam logic [WordW-1:0] SipC0 = 64'h736f6d6570736575;
	localparam logic [WordW-1:0] SipC1 = 64'h646f72616e646f6d;
	localparam logic [WordW-1:0] SipC2 = 64'h6c7967656e657261;
	localparam logic [WordW-1:0] SipC3 = 64'h7465646279746573;
	localparam logic [WordW-1:0] FinXor = 64'h00000000000000ff;

	localparam logic [CfgIdxW-1:0] RegKeyLow  = 2'd0;
	localparam logic [CfgIdxW-1:0] RegKeyHigh = 2'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ABS1,
		ST_ABS2,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [WordW-1:0] v0;
		logic [WordW-1:0] v1;
		logic [WordW-1:0] v2;
		logic [WordW-1:0] v3;
	} lanes_t;

	typedef struct packed {
		logic accept;
		logic round;
		logic absorb_end;
		logic len_word;
		logic xor_ff;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic full;
		logic out_free;
	} status_t;

	function automatic logic [WordW-1:0] rol(input logic [WordW-1:0] x, input int unsigned n);
		rol = (x << n) | (x >> (WordW - n));
	endfunction

	function automatic lanes_t sip_round(input lanes_t v);
		logic [WordW-1:0] a;
		logic [WordW-1:0] b;
		logic [WordW-1:0] c;
		logic [WordW-1:0] d;
		a = v.v0 + v.v1;
		b = rol(v.v1, 13) ^ a;
		a = rol(a, 32);
		c = v.v2 + v.v3;
		d = rol(v.v3, 16) ^ c;
		c = c + b;
		b = rol(b, 17) ^ c;
		c = rol(c, 32);
		a = a + d;
		d = rol(d, 21) ^ a;
		sip_round = '{v0: a, v1: b, v2: c, v3: d};
	endfunction

endpackage

// File: hw/rtl/siphash_2_4_stream.sv
`timescale 1ns / 1ps
// keyed siphash-2-4 over a stream of little-endian 64-bit words
// config channel: cfg_valid/cfg_ready, cfg_index 0 = key low half, 1 = key high half;
//   always ready, other indexes ignored; the key is sampled by the first beat of a message
// input channel: in_valid/in_ready with data_word, byte_count, last_word; byte_count is
//   only used on the last beat and saturates at 8
// output channel: out_valid/out_ready with hash_value, one beat per message
// one sipround per clock through a single round unit: a non-last word is mixed in ABS1
//   and ABS2, and the next word can be taken in ABS2
// last word: absorbed in ABS1 and ABS2, then absorbed again with a length-only word
//   when it carries all 8 bytes; then 4 finalization rounds in DRAIN, and EMIT loads the
//   output register; the next message can be taken from the cycle the hash appears on
// the output register holds the hash while the receiver stalls; a new message keeps
//   streaming and only waits at its own hash if the previous one is still untaken
// reset: key cleared to zero, no message open, output empty
module siphash_2_4_stream (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [sh24_pkg::CfgIdxW-1:0]          cfg_index,
	input  logic [sh24_pkg::WordW-1:0]            cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [sh24_pkg::WordW-1:0]            data_word,
	input  logic [sh24_pkg::CountW-1:0]           byte_count,
	input  logic                                  last_word,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [sh24_pkg::WordW-1:0]            hash_value
);

	sh24_pkg::cmd_t    cmd;
	sh24_pkg::status_t status;

	assign cfg_ready = 1'b1;

	sh24_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	sh24_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.data_word  (data_word),
		.byte_count (byte_count),
		.last_word  (last_word),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.hash_value (hash_value),
		.cmd        (cmd),
		.status     (status)
	);

endmodule

// File: hw/rtl/sh24_ctrl.sv
`timescale 1ns / 1ps

module sh24_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  sh24_pkg::status_t   status,
	output sh24_pkg::cmd_t      cmd
);

	sh24_pkg::state_t state_q;
	sh24_pkg::state_t state_d;
	logic [sh24_pkg::DrainCntW-1:0] cnt_q;
	logic extra_q;
	logic drain_done;
	logic need_extra;

	assign drain_done = (cnt_q == sh24_pkg::DrainCntW'(sh24_pkg::DrainRounds - 1));
	assign need_extra = status.last && status.full && !extra_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sh24_pkg::ST_IDLE;
			cnt_q   <= '0;
			extra_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == sh24_pkg::ST_DRAIN) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			if (state_q == sh24_pkg::ST_ABS2) begin
				extra_q <= need_extra;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sh24_pkg::ST_IDLE: begin
				if (in_valid) state_d = sh24_pkg::ST_ABS1;
			end
			sh24_pkg::ST_ABS1: begin
				state_d = sh24_pkg::ST_ABS2;
			end
			sh24_pkg::ST_ABS2: begin
				if (!status.last) begin
					state_d = in_valid ? sh24_pkg::ST_ABS1 : sh24_pkg::ST_IDLE;
				end else if (need_extra) begin
					state_d = sh24_pkg::ST_ABS1;
				end else begin
					state_d = sh24_pkg::ST_DRAIN;
				end
			end
			sh24_pkg::ST_DRAIN: begin
				if (drain_done) state_d = sh24_pkg::ST_EMIT;
			end
			sh24_pkg::ST_EMIT: begin
				if (status.out_free) state_d = sh24_pkg::ST_IDLE;
			end
			default: state_d = sh24_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			sh24_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			sh24_pkg::ST_ABS1: begin
				cmd.round = 1'b1;
			end
			sh24_pkg::ST_ABS2: begin
				cmd.round      = 1'b1;
				cmd.absorb_end = 1'b1;
				if (!status.last) begin
					in_ready   = 1'b1;
					cmd.accept = in_valid;
				end else if (need_extra) begin
					cmd.len_word = 1'b1;
				end else begin
					cmd.xor_ff = 1'b1;
				end
			end
			sh24_pkg::ST_DRAIN: begin
				cmd.round = 1'b1;
			end
			sh24_pkg::ST_EMIT: begin
				cmd.emit = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_ready_states: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (state_q == sh24_pkg::ST_IDLE || state_q == sh24_pkg::ST_ABS2))
		else $error("in_ready outside idle or second round");
	a_drain_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sh24_pkg::ST_DRAIN && drain_done) |=> state_q == sh24_pkg::ST_EMIT)
		else $error("finalization did not end after four rounds");
	a_extra_full: assert property (@(posedge clk) disable iff (!arst_n)
		(extra_q && state_q == sh24_pkg::ST_ABS2) |-> (status.last && status.full))
		else $error("length-only block absorbed without a full last word");
`endif

endmodule

// File: hw/rtl/sh24_datapath.sv
`timescale 1ns / 1ps

module sh24_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [sh24_pkg::CfgIdxW-1:0]          cfg_index,
	input  logic [sh24_pkg::WordW-1:0]            cfg_data,
	input  logic [sh24_pkg::WordW-1:0]            data_word,
	input  logic [sh24_pkg::CountW-1:0]           byte_count,
	input  logic                                  last_word,
	input  logic                                  out_ready,
	output logic                                  out_valid,
	output logic [sh24_pkg::WordW-1:0]            hash_value,
	input  sh24_pkg::cmd_t                        cmd,
	output sh24_pkg::status_t                     status
);

	logic [sh24_pkg::WordW-1:0] key_low_q;
	logic [sh24_pkg::WordW-1:0] key_high_q;
	sh24_pkg::lanes_t lanes_q;
	sh24_pkg::lanes_t lanes_d;
	sh24_pkg::lanes_t rnd;
	sh24_pkg::lanes_t init;
	logic [sh24_pkg::WordW-1:0] m_q;
	logic [sh24_pkg::WordW-1:0] m_d;
	logic [sh24_pkg::LenW-1:0] len_q;
	logic [sh24_pkg::LenW-1:0] len_new;
	logic [sh24_pkg::LenW-1:0] len_base;
	logic [sh24_pkg::LenW-1:0] len_add;
	logic in_msg_q;
	logic last_q;
	logic full_q;
	logic out_valid_q;
	logic [sh24_pkg::WordW-1:0] hash_q;
	logic [sh24_pkg::CountW-1:0] cnt_sat;
	logic full_in;
	logic [sh24_pkg::BytesPerW-1:0] keep;
	logic [sh24_pkg::WordW-1:0] masked;
	logic [sh24_pkg::WordW-1:0] word_in;
	logic [sh24_pkg::WordW-1:0] len_word;

	assign cnt_sat  = (byte_count > sh24_pkg::CountW'(sh24_pkg::BytesPerW))
		? sh24_pkg::CountW'(sh24_pkg::BytesPerW) : byte_count;
	assign full_in  = (cnt_sat == sh24_pkg::CountW'(sh24_pkg::BytesPerW));
	assign len_base = in_msg_q ? len_q : '0;
	assign len_add  = last_word ? sh24_pkg::LenW'(cnt_sat) : sh24_pkg::LenW'(sh24_pkg::BytesPerW);
	assign len_new  = len_base + len_add;
	assign len_word = {len_q, {(sh24_pkg::WordW - sh24_pkg::LenW){1'b0}}};

	always_comb begin
		for (int i = 0; i < sh24_pkg::BytesPerW; i++) begin
			keep[i] = (sh24_pkg::CountW'(i) < cnt_sat);
			masked[i*8 +: 8] = keep[i] ? data_word[i*8 +: 8] : 8'h00;
		end
	end

	assign word_in = (last_word && !full_in)
		? ({len_new, {(sh24_pkg::WordW - sh24_pkg::LenW){1'b0}}}
			| {8'h00, masked[sh24_pkg::WordW-sh24_pkg::LenW-1:0]})
		: data_word;

	assign init = '{v0: key_low_q ^ sh24_pkg::SipC0, v1: key_high_q ^ sh24_pkg::SipC1,
		v2: key_low_q ^ sh24_pkg::SipC2, v3: key_high_q ^ sh24_pkg::SipC3};

	assign rnd = sh24_pkg::sip_round(lanes_q);

	always_comb begin
		lanes_d = cmd.round ? rnd : lanes_q;
		m_d     = m_q;
		if (cmd.absorb_end) lanes_d.v0 = lanes_d.v0 ^ m_q;
		if (cmd.xor_ff) lanes_d.v2 = lanes_d.v2 ^ sh24_pkg::FinXor;
		if (cmd.len_word) begin
			lanes_d.v3 = lanes_d.v3 ^ len_word;
			m_d        = len_word;
		end
		if (cmd.accept) begin
			if (!in_msg_q) lanes_d = init;
			lanes_d.v3 = lanes_d.v3 ^ word_in;
			m_d        = word_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q   <= '0;
			key_high_q  <= '0;
			in_msg_q    <= 1'b0;
			len_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == sh24_pkg::RegKeyLow) key_low_q <= cfg_data;
			if (cfg_we && cfg_index == sh24_pkg::RegKeyHigh) key_high_q <= cfg_data;
			if (cmd.accept) begin
				in_msg_q <= 1'b1;
				len_q    <= len_new;
			end else if (cmd.emit) begin
				in_msg_q <= 1'b0;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		lanes_q <= lanes_d;
		m_q     <= m_d;
		if (cmd.accept) begin
			last_q <= last_word;
			full_q <= full_in;
		end
		if (cmd.emit) hash_q <= lanes_q.v0 ^ lanes_q.v1 ^ lanes_q.v2 ^ lanes_q.v3;
	end

	assign status.last     = last_q;
	assign status.full     = full_q;
	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign hash_value      = hash_q;

`ifndef SYNTHESIS
	a_emit_closes: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (!in_msg_q && out_valid_q))
		else $error("emit did not close the message and present the hash");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("hash overwritten before it was taken");
`endif

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int unsigned CycleLimit  = 500000;
	localparam int unsigned DrainCycles = 16;
	localparam logic [sh24_pkg::CfgIdxW-1:0] IdxUnused = 2'd2;

	class sip_hash_board;
		logic [63:0] key_lo;
		logic [63:0] key_hi;
		logic [63:0] va, vb, vc, vd;
		logic [7:0]  msg_len;
		bit          msg_open;
		logic [63:0] due_hashes[$];
		int unsigned n_words, n_msgs, n_checked, n_keys, n_errors;

		function void clear();
			key_lo = '0;
			key_hi = '0;
			va = '0;
			vb = '0;
			vc = '0;
			vd = '0;
			msg_len = '0;
			msg_open = 1'b0;
			due_hashes.delete();
			n_words = 0;
			n_msgs = 0;
			n_checked = 0;
			n_keys = 0;
			n_errors = 0;
		endfunction

		function void sip_round_step();
			va = va + vb;
			vb = {vb[50:0], vb[63:51]} ^ va;
			va = {va[31:0], va[63:32]};
			vc = vc + vd;
			vd = {vd[47:0], vd[63:48]} ^ vc;
			vc = vc + vb;
			vb = {vb[46:0], vb[63:47]} ^ vc;
			vc = {vc[31:0], vc[63:32]};
			va = va + vd;
			vd = {vd[42:0], vd[63:43]} ^ va;
		endfunction

		function void mix_word(logic [63:0] w);
			vd = vd ^ w;
			sip_round_step();
			sip_round_step();
			va = va ^ w;
		endfunction

		function void take_key(logic [sh24_pkg::CfgIdxW-1:0] idx, logic [63:0] val);
			n_keys++;
			if (idx == sh24_pkg::RegKeyLow)
				key_lo = val;
			else if (idx == sh24_pkg::RegKeyHigh)
				key_hi = val;
		endfunction

		function void take_word(logic [63:0] w, logic [3:0] cnt, logic is_last);
			logic [63:0] tail;
			int unsigned nb;
			n_words++;
			if (!msg_open) begin
				va = key_lo ^ sh24_pkg::SipC0;
				vb = key_hi ^ sh24_pkg::SipC1;
				vc = key_lo ^ sh24_pkg::SipC2;
				vd = key_hi ^ sh24_pkg::SipC3;
				msg_len = '0;
				msg_open = 1'b1;
			end
			if (!is_last) begin
				mix_word(w);
				msg_len = msg_len + 8'd8;
				return;
			end
			nb = (cnt > 4'd8) ? 8 : cnt;
			if (nb == 8) begin
				mix_word(w);
				msg_len = msg_len + 8'd8;
				tail = '0;
			end else begin
				tail = w & ~({64{1'b1}} << (nb * 8));
				msg_len = msg_len + 8'(nb);
			end
			tail[63:56] = msg_len;
			mix_word(tail);
			vc = vc ^ 64'hff;
			repeat (4) sip_round_step();
			due_hashes.push_back(va ^ vb ^ vc ^ vd);
			msg_open = 1'b0;
			n_msgs++;
		endfunction

		function void check_hash(logic [63:0] got);
			logic [63:0] want;
			if (due_hashes.size() == 0) begin
				$error("hash_value beat with nothing pending: actual %h", got);
				n_errors++;
				return;
			end
			want = due_hashes.pop_front();
			n_checked++;
			if (got !== want) begin
				$error("hash_value mismatch: expected %h, actual %h", want, got);
				n_errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [sh24_pkg::CfgIdxW-1:0] cfg_index = '0;
	logic [sh24_pkg::WordW-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [sh24_pkg::WordW-1:0] data_word = '0;
	logic [sh24_pkg::CountW-1:0] byte_count = '0;
	logic last_word = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [sh24_pkg::WordW-1:0] hash_value;

	int unsigned send_idle = 30;
	int unsigned recv_idle = 80;
	int unsigned cycle_count = 0;

	sip_hash_board board = new;

	siphash_2_4_stream i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_word  (data_word),
		.byte_count (byte_count),
		.last_word  (last_word),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hash_value (hash_value)
	);

	always #4 clk = ~clk;

	// hash receiver with random back-pressure
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_hash(hash_value);
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	initial begin
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("testbench failed");
		$finish;
	end

	task automatic send_word(input logic [63:0] w, input logic [3:0] cnt, input logic is_last);
		in_valid <= 1'b1;
		data_word <= w;
		byte_count <= cnt;
		last_word <= is_last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		board.take_word(w, cnt, is_last);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic cfg_beat(input logic [sh24_pkg::CfgIdxW-1:0] idx, input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		board.take_key(idx, val);
	endtask

	task automatic set_key(input logic [63:0] k0, input logic [63:0] k1);
		cfg_beat(sh24_pkg::RegKeyLow, k0);
		cfg_beat(sh24_pkg::RegKeyHigh, k1);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (board.due_hashes.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic send_message();
		int unsigned pick;
		int unsigned n_full;
		logic [3:0] cnt;
		pick = $urandom_range(99);
		if (pick < 3)
			n_full = $urandom_range(40, 31);
		else if (pick < 20)
			n_full = 0;
		else
			n_full = $urandom_range(6, 1);
		repeat (n_full)
			send_word({$urandom, $urandom}, 4'($urandom_range(15)), 1'b0);
		pick = $urandom_range(9);
		cnt = (pick == 9) ? 4'($urandom_range(15, 9)) : 4'(pick);
		send_word({$urandom, $urandom}, cnt, 1'b1);
	endtask

	task automatic random_phase(input int unsigned n_items);
		int unsigned goal;
		goal = board.n_words + n_items;
		while (board.n_words < goal) begin
			send_message();
			if ($urandom_range(99) < 5) begin
				wait_idle();
				case ($urandom_range(3))
					0: set_key('0, {$urandom, $urandom});
					1: set_key('1, {$urandom, $urandom});
					default: set_key({$urandom, $urandom}, {$urandom, $urandom});
				endcase
			end
		end
	endtask

	initial begin
		board.clear();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero key from reset: empty message, then a lone full word
		send_word(64'h0123456789abcdef, 4'd0, 1'b1);
		send_word('1, 4'd8, 1'b1);
		wait_idle();
		cfg_beat(IdxUnused, '1);
		set_key(64'h0706050403020100, 64'h0f0e0d0c0b0a0908);
		// 15-byte message, junk above the tail must be masked
		send_word(64'h0706050403020100, 4'd15, 1'b0);
		send_word(64'hff0e0d0c0b0a0908, 4'd7, 1'b1);
		// oversized counts saturate to a full word
		send_word('0, 4'd9, 1'b1);
		send_word('1, 4'd15, 1'b1);
		send_word('1, 4'd1, 1'b1);
		send_word('1, 4'd0, 1'b0);
		send_word('1, 4'd8, 1'b1);
		wait_idle();
		set_key('1, '1);
		send_word('0, 4'd0, 1'b1);
		send_word(64'h8000000000000001, 4'd3, 1'b1);
		// key written while a message is open only hits the next one
		send_word(64'hdeadbeefcafef00d, 4'd5, 1'b0);
		wait_idle();
		set_key('0, '1);
		send_word(64'h5555aaaa5555aaaa, 4'd6, 1'b1);
		send_word('0, 4'd0, 1'b1);
		wait_idle();
		set_key('1, '0);
		send_word(64'h00000000000000ff, 4'd2, 1'b1);
		wait_idle();

		set_key({$urandom, $urandom}, {$urandom, $urandom});
		random_phase(470);
		wait_idle();

		send_idle = 80;
		recv_idle = 30;
		set_key({$urandom, $urandom}, {$urandom, $urandom});
		random_phase(470);
		wait_idle();

		send_idle = 0;
		recv_idle = 0;
		set_key({$urandom, $urandom}, {$urandom, $urandom});
		random_phase(470);
		wait_idle();

		$display("run covered %0d words in %0d messages, %0d hashes checked, %0d key beats",
			board.n_words, board.n_msgs, board.n_checked, board.n_keys);
		$display("%0d cycles, %0d errors", cycle_count, board.n_errors);
		if (board.n_errors == 0 && board.due_hashes.size() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
